@@ hw/rtl/ukc_pkg.sv @@
package ukc_pkg;

  // Widths of the item fields.
  localparam int OP_W     = 2;
  localparam int KEY_W    = 16;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Operation codes; the unused code is handled as a lookup.
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNCHANGED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic match;
    logic encode;
    logic update;
  } ukc_cmd_t;

endpackage

@@ hw/rtl/unique_key_set_compacting.sv @@
// Set of distinct keys kept packed in insertion order, with a stored count.
// Input channel (in_valid/in_ready) carries one word: operation and key.
// Add appends an absent key, delete removes a present key and closes the
// gap, lookup reports where a key sits. The output channel
// (out_valid/out_ready) returns one word per input word: found, position,
// entry_count and status.
// Each word passes through acceptance, a compare of all cells at once,
// a first-match encode, and the update that also loads the output register.
// A new word is accepted only once the last word is through this controller
// sequence; a word whose result cannot enter a full output register waits
// in the update step until the receiver takes the pending word.
// The input side is open again as soon as the result is in the output
// register, so the next word may be accepted while the receiver stalls.
// Reset empties the set (count zero) and clears the output valid flag;
// cell contents are not cleared, since only counted cells are ever read.
module unique_key_set_compacting
  import ukc_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     operation,
  input  logic [KEY_W-1:0]    key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                found,
  output logic [POS_W-1:0]    position,
  output logic [COUNT_W-1:0]  entry_count,
  output logic [STATUS_W-1:0] status
);

  ukc_cmd_t                        cmd;
  logic [$clog2(CAPACITY+1)-1:0]   count;

  ukc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ukc_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (operation),
    .key         (key),
    .found       (found),
    .position    (position),
    .entry_count (entry_count),
    .status      (status),
    .count_out   (count)
  );

  // The stored count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ($clog2(CAPACITY+1))'(CAPACITY))
    else $error("stored count above capacity");

  // A result is only written into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (!out_valid || out_ready))
    else $error("output word overwritten");

  // After a word is accepted the input side is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted during processing");

  // A refused add never reports a hit.
  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> !found)
    else $error("full status with found set");

endmodule

@@ hw/rtl/ukc_ctrl.sv @@
module ukc_ctrl
  import ukc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ukc_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_ENCODE,
    S_UPDATE
  } state_t;

  state_t state;
  logic   out_free;

  // The output register can take a new word when empty or being drained.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Command decode from the current state.
  always_comb begin
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.match  = (state == S_MATCH);
    cmd.encode = (state == S_ENCODE);
    cmd.update = (state == S_UPDATE) && out_free;
  end

  // State sequence and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE:   if (in_valid) state <= S_MATCH;
        S_MATCH:  state <= S_ENCODE;
        S_ENCODE: state <= S_UPDATE;
        S_UPDATE: if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
      if (cmd.update) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/ukc_datapath.sv @@
module ukc_datapath
  import ukc_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ukc_cmd_t             cmd,
  input  logic [OP_W-1:0]      operation,
  input  logic [KEY_W-1:0]     key,
  output logic                 found,
  output logic [POS_W-1:0]     position,
  output logic [COUNT_W-1:0]   entry_count,
  output logic [STATUS_W-1:0]  status,
  output logic [$clog2(CAPACITY+1)-1:0] count_out
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [KEY_BITS-1:0] entries [CAPACITY];
  logic [CNT_W-1:0]    count;
  logic [OP_W-1:0]     op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [CAPACITY-1:0] hit_vec;
  logic                hit_q;
  logic [IDX_W-1:0]    pos_q;
  logic [IDX_W-1:0]    first_pos;
  logic                is_full;
  logic [31:0]         key_wide;
  logic [31:0]         pos_wide;
  logic [31:0]         count_wide;
  logic [CNT_W-1:0]    count_next;
  logic [STATUS_W-1:0] status_next;

  assign key_wide  = {{(32 - KEY_W){1'b0}}, key};
  assign is_full   = (count == CNT_W'(CAPACITY));
  assign count_out = count;

  // Lowest matching cell wins.
  always_comb begin
    first_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit_vec[i]) first_pos = IDX_W'(i);
    end
  end

  // Outcome of the operation from the registered search result.
  always_comb begin
    count_next  = count;
    status_next = hit_q ? ST_DONE : ST_UNCHANGED;
    case (op_q)
      OP_ADD: begin
        if (hit_q) begin
          status_next = ST_UNCHANGED;
        end else if (is_full) begin
          status_next = ST_FULL;
        end else begin
          count_next  = count + 1'b1;
          status_next = ST_DONE;
        end
      end
      OP_DELETE: begin
        if (hit_q) count_next = count - 1'b1;
      end
      default: ;
    endcase
  end

  assign pos_wide   = {{(32 - IDX_W){1'b0}}, pos_q};
  assign count_wide = {{(32 - CNT_W){1'b0}}, count_next};

  // Item capture, parallel compare and first-match encode.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      key_q <= key_wide[KEY_BITS-1:0];
    end
    if (cmd.match) begin
      for (int i = 0; i < CAPACITY; i++) begin
        hit_vec[i] <= (entries[i] == key_q) && (CNT_W'(i) < count);
      end
    end
    if (cmd.encode) begin
      hit_q <= |hit_vec;
      pos_q <= first_pos;
    end
  end

  // Cell array: append at the end, or shift later cells down on delete.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (op_q == OP_ADD && !hit_q && !is_full) begin
        entries[count[IDX_W-1:0]] <= key_q;
      end
      if (op_q == OP_DELETE && hit_q) begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (IDX_W'(i) >= pos_q) entries[i] <= entries[i + 1];
        end
      end
    end
  end

  // Stored count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.update) begin
      count <= count_next;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      found       <= hit_q;
      position    <= hit_q ? pos_wide[POS_W-1:0] : '0;
      entry_count <= count_wide[COUNT_W-1:0];
      status      <= status_next;
    end
  end

endmodule

@@ sim/tb_unique_key_set_compacting.sv @@
module tb_unique_key_set_compacting;
  import ukc_pkg::*;

  localparam int SET_DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 80;
  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 100;
  localparam int POOL_SIZE = 20;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One result word as the block reports it.
  typedef struct packed {
    logic                found;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  entry_count;
    logic [STATUS_W-1:0] status;
  } set_result_t;

  // One row of the directed stimulus; typed rows carry a hand-written result.
  typedef struct {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    bit               typed;
    set_result_t      want;
  } probe_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     operation;
  logic [KEY_W-1:0]    key;
  logic                out_valid;
  logic                out_ready;
  logic                found;
  logic [POS_W-1:0]    position;
  logic [COUNT_W-1:0]  entry_count;
  logic [STATUS_W-1:0] status;

  // Predictor state: the stored keys in order and their count.
  // Only the first model_count keys are ever read.
  logic [KEY_W-1:0] model_keys [SET_DEPTH];
  int unsigned      model_count = 0;

  set_result_t      pending_results [$];
  probe_row_t       probe_rows [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  // Hand-written expectation travelling with the word on the input side.
  bit          word_typed;
  set_result_t word_want;

  set_result_t got_res;
  set_result_t want_res;
  int          err_count = 0;
  int          result_idx = 0;
  int          quiet_cycles = 0;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_request;

  unique_key_set_compacting #(
    .CAPACITY(SET_DEPTH),
    .KEY_BITS(KEY_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .key(key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .position(position),
    .entry_count(entry_count),
    .status(status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Applies one operation to the predictor set and returns the result word.
  function automatic set_result_t apply_set_op(input logic [OP_W-1:0] op,
                                               input logic [KEY_W-1:0] k);
    set_result_t res;
    int hit_at;
    hit_at = -1;
    for (int i = 0; i < model_count; i++) begin
      if (hit_at < 0 && model_keys[i] == k) hit_at = i;
    end
    res.found = (hit_at >= 0);
    res.position = (hit_at >= 0) ? hit_at[POS_W-1:0] : '0;
    case (op)
      OP_ADD: begin
        if (hit_at >= 0) begin
          res.status = ST_UNCHANGED;
        end else if (model_count >= SET_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          model_keys[model_count] = k;
          model_count++;
          res.status = ST_DONE;
        end
      end
      OP_DELETE: begin
        if (hit_at >= 0) begin
          // Close the gap: every later key moves down one place.
          for (int i = hit_at; i + 1 < model_count; i++) begin
            model_keys[i] = model_keys[i+1];
          end
          model_count--;
          res.status = ST_DONE;
        end else begin
          res.status = ST_UNCHANGED;
        end
      end
      default: begin
        // Lookup, and the unused code that behaves as one.
        res.status = (hit_at >= 0) ? ST_DONE : ST_UNCHANGED;
      end
    endcase
    res.entry_count = model_count[COUNT_W-1:0];
    return res;
  endfunction

  // Keys are drawn mostly from the stored set or a small pool so that hits are common.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && model_count > 0) return model_keys[$urandom_range(0, model_count - 1)];
    if (r < 88) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return KEY_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int add_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_pct) return OP_ADD;
    if (r < add_pct + (100 - add_pct) * 55 / 100) return OP_DELETE;
    if (r < 96) return OP_LOOKUP;
    return OP_UNUSED;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    if (err_count < 40) begin
      $display("Mismatch on result %0d, %s: got %0d, expected %0d",
               result_idx, what, got_v, want_v);
    end
    err_count++;
  endtask

  task automatic push_row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                          input bit typed, input set_result_t want);
    probe_row_t row;
    row.op = op;
    row.key = k;
    row.typed = typed;
    row.want = want;
    probe_rows.push_back(row);
  endtask

  // Offers one word and returns at the falling edge after it was taken.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                           input bit typed, input set_result_t want);
    in_valid = 1'b1;
    operation = op;
    key = k;
    word_typed = typed;
    word_want = want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    in_valid = 1'b0;
    operation = OP_W'($urandom);
    key = KEY_W'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  // Sender pauses until every pending result has come back.
  task automatic drain();
    in_valid = 1'b0;
    word_typed = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Checking and watchdog, all at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      // Outputs first, so a word accepted at the same edge is queued behind.
      if (out_valid && out_ready) begin
        got_res = '{found, position, entry_count, status};
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", int'(got_res), 0);
        end else begin
          want_res = pending_results.pop_front();
          if (got_res.found !== want_res.found)
            report_mismatch("found", int'(got_res.found), int'(want_res.found));
          if (got_res.position !== want_res.position)
            report_mismatch("position", int'(got_res.position), int'(want_res.position));
          if (got_res.entry_count !== want_res.entry_count)
            report_mismatch("entry_count", int'(got_res.entry_count),
                            int'(want_res.entry_count));
          if (got_res.status !== want_res.status)
            report_mismatch("status", int'(got_res.status), int'(want_res.status));
        end
        result_idx++;
      end
      if (in_valid && in_ready) begin
        want_res = apply_set_op(operation, key);
        if (word_typed) want_res = word_want;
        pending_results.push_back(want_res);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold when asked for.
  initial begin
    int stall_left;
    bit hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request && !hold_taken) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_taken = 1'b1;
        out_ready = 1'b1;
      end else if (rx_idle_on && stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_ready = 1'b1;
      end
      @(negedge clk);
    end
  end

  // Sender: directed table, then random phases.
  initial begin
    int add_bias [PHASES];
    logic [KEY_W-1:0] fill_key;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_ADD;
    key = '0;
    word_typed = 1'b0;
    word_want = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_request = 1'b0;
    add_bias = '{70, 35, 85, 50, 25, 60};

    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom_range(0, 65535));
    key_pool[0] = '0;
    key_pool[1] = '1;

    // Directed part: empty set, extremes, duplicates, unused code, fill to full.
    push_row(OP_LOOKUP, 16'h0000, 1'b1, set_result_t'{1'b0, 4'd0, 5'd0, ST_UNCHANGED});
    push_row(OP_DELETE, 16'hFFFF, 1'b1, set_result_t'{1'b0, 4'd0, 5'd0, ST_UNCHANGED});
    push_row(OP_ADD, 16'h0000, 1'b1, set_result_t'{1'b0, 4'd0, 5'd1, ST_DONE});
    push_row(OP_ADD, 16'hFFFF, 1'b1, set_result_t'{1'b0, 4'd0, 5'd2, ST_DONE});
    push_row(OP_ADD, 16'h0000, 1'b1, set_result_t'{1'b1, 4'd0, 5'd2, ST_UNCHANGED});
    push_row(OP_LOOKUP, 16'hFFFF, 1'b1, set_result_t'{1'b1, 4'd1, 5'd2, ST_DONE});
    push_row(OP_UNUSED, 16'h0000, 1'b1, set_result_t'{1'b1, 4'd0, 5'd2, ST_DONE});
    push_row(OP_DELETE, 16'h0000, 1'b1, set_result_t'{1'b1, 4'd0, 5'd1, ST_DONE});
    for (int i = 1; i < SET_DEPTH; i++) begin
      fill_key = KEY_W'(16'h0101 * i);
      push_row(OP_ADD, fill_key, 1'b0, '0);
    end
    push_row(OP_ADD, 16'hA5A5, 1'b1, set_result_t'{1'b0, 4'd0, 5'd16, ST_FULL});
    push_row(OP_DELETE, 16'h0F0F, 1'b0, '0);
    push_row(OP_DELETE, 16'hFFFF, 1'b0, '0);

    repeat (9) @(negedge clk);
    rst = 1'b0;

    foreach (probe_rows[i]) begin
      send_word(probe_rows[i].op, probe_rows[i].key, probe_rows[i].typed,
                probe_rows[i].want);
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 18));
    end
    drain();

    // Random phases with different add bias; the last one runs with no idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      tx_idle_on = (phase < PHASES - 1);
      rx_idle_on = (phase < PHASES - 1);
      // Receiver holds off while words keep coming, so the block backs up.
      if (phase == 1) hold_request = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(pick_op(add_bias[phase]), pick_key(), 1'b0, '0);
        if (tx_idle_on && $urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 18));
      end
      drain();
    end

    repeat (12) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
